/* hw/rtl/bitmap_run_allocator_top_assert.svh */
// Assertion macros shared by the bitmap run allocator RTL.
`ifndef BITMAP_RUN_ALLOCATOR_TOP_ASSERT_SVH
`define BITMAP_RUN_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define BRA_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bitmap_run_allocator: property failed");
`define BRA_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("bitmap_run_allocator: forbidden condition seen");
`else
`define BRA_ASSERT(name, prop)
`define BRA_ASSERT_NEVER(name, cond)
`endif

`endif

/* hw/rtl/bra_pkg.sv */
// Types and constants shared by the bitmap run allocator modules.
package bra_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned WORD_SH = 6;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned LEN_W   = 8;

  localparam logic [LEN_W-1:0] LEN_RESET = 8'd128;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_TEST  = 2'd1,
    OP_SCAN  = 2'd2,
    OP_WRITE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_ACC_RD,
    ST_ACC_EX,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic acc_rd;
    logic acc_ex;
    logic scan_issue;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cnt_zero;
    logic all_issued;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

/* hw/rtl/bra_ctrl.sv */
// Sequencer for the bitmap run allocator: clearing pass, access and scan control.
module bra_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           operation_i,
  input  bra_pkg::dp_status_t  status_i,
  output bra_pkg::ctrl_cmd_t   cmd_o,
  output logic                 in_ready_o
);
  import bra_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        // The map is swept to zero once after reset.
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (op_e'(operation_i))
            OP_CLEAR: state_d = ST_CLEAR;
            OP_TEST:  state_d = ST_ACC_RD;
            OP_WRITE: state_d = ST_ACC_RD;
            OP_SCAN:  state_d = ST_SCAN;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_DONE;
        end
      end
      ST_ACC_RD: begin
        cmd_o.acc_rd = 1'b1;
        state_d      = ST_ACC_EX;
      end
      ST_ACC_EX: begin
        cmd_o.acc_ex = 1'b1;
        state_d      = ST_DONE;
      end
      ST_SCAN: begin
        if (status_i.cnt_zero || status_i.scan_done) begin
          state_d = ST_DONE;
        end else if (!status_i.all_issued) begin
          cmd_o.scan_issue = 1'b1;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

endmodule

/* hw/rtl/bra_datapath.sv */
// Datapath of the bitmap run allocator: map memory, run search pipeline, result registers.
module bra_datapath #(
  parameter int unsigned MAP_BYTES = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bra_pkg::LEN_W-1:0]   cfg_wdata_i,
  input  logic [1:0]                  operation_i,
  input  logic [bra_pkg::IDX_W-1:0]   bit_index_i,
  input  logic                        value_i,
  input  logic [bra_pkg::CNT_W-1:0]   count_i,
  input  logic                        out_ready_i,
  input  bra_pkg::ctrl_cmd_t          cmd_i,
  output bra_pkg::dp_status_t         status_o,
  output logic                        out_valid_o,
  output logic                        found_o,
  output logic [bra_pkg::IDX_W-1:0]   start_index_o,
  output logic                        bit_value_o
);
  import bra_pkg::*;

  localparam int unsigned WORDS = (MAP_BYTES * 8 + WORD_W - 1) / WORD_W;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CW    = AW + 1;

  // Map storage and its registered read port.
  logic [WORD_W-1:0] mem_q [WORDS];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  // Configuration and latched request.
  logic [LEN_W-1:0]  len_q;
  logic [POS_W-1:0]  len_ext, limit_d, limit_q;
  logic [CW-1:0]     nw_d, nw_q;
  op_e               op_q;
  logic [IDX_W-1:0]  idx_q;
  logic              val_q;
  logic [CNT_W-1:0]  cnt_q;

  // Sequencing counters and scan pipeline.
  logic [AW-1:0]     clr_addr_q;
  logic [CW-1:0]     scan_cnt_q;
  logic              s1_v_q, s2_v_q;
  logic [AW-1:0]     s1_word_q, s2_word_q;
  logic [POS_W-1:0]  carry_q;
  logic [WORD_W-1:0] hit_d, hit_q;

  logic [WORD_SH:0]  pre_s [WORD_W];
  logic [POS_W-1:0]  run_s [WORD_W];
  logic [POS_W-1:0]  gpos_s [WORD_W];

  logic [WORD_W-1:0]  first_oh;
  logic [WORD_SH-1:0] first_j;
  logic               any_hit;
  logic [POS_W-1:0]   start_calc;

  logic              in_range;
  logic [AW-1:0]     acc_addr;
  logic [WORD_W-1:0] wr_word;
  logic              scan_hit;

  // Result and output registers.
  logic              res_found_q, res_bit_q;
  logic [IDX_W-1:0]  res_start_q;
  logic              out_valid_q, out_found_q, out_bit_q;
  logic [IDX_W-1:0]  out_start_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
    end
  end

  // Lengths above the physical map size behave as the full map.
  always_comb begin
    len_ext = POS_W'(len_q);
    if (len_ext > POS_W'(MAP_BYTES)) begin
      len_ext = POS_W'(MAP_BYTES);
    end
    limit_d = len_ext << 3;
    nw_d    = CW'((limit_d + POS_W'(WORD_W - 1)) >> WORD_SH);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= op_e'(operation_i);
      idx_q   <= bit_index_i;
      val_q   <= value_i;
      cnt_q   <= count_i;
      limit_q <= limit_d;
      nw_q    <= nw_d;
    end
  end

  assign in_range = POS_W'(idx_q) < limit_q;
  assign acc_addr = AW'(POS_W'(idx_q) >> WORD_SH);

  always_comb begin
    wr_word = rdata_q;
    wr_word[idx_q[WORD_SH-1:0]] = val_q;
  end

  assign mem_we    = cmd_i.clr_step || (cmd_i.acc_ex && op_q == OP_WRITE && in_range);
  assign mem_waddr = cmd_i.clr_step ? clr_addr_q : acc_addr;
  assign mem_wdata = cmd_i.clr_step ? '0 : wr_word;
  assign mem_re    = cmd_i.acc_rd || cmd_i.scan_issue;
  assign mem_raddr = cmd_i.acc_rd ? acc_addr : scan_cnt_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      scan_cnt_q <= '0;
      s1_v_q     <= 1'b0;
      s2_v_q     <= 1'b0;
      carry_q    <= '0;
    end else begin
      s1_v_q <= cmd_i.scan_issue;
      s2_v_q <= s1_v_q;
      if (cmd_i.accept) begin
        clr_addr_q <= '0;
        scan_cnt_q <= '0;
        carry_q    <= '0;
      end else begin
        if (cmd_i.clr_step) begin
          clr_addr_q <= clr_addr_q + AW'(1);
        end
        if (cmd_i.scan_issue) begin
          scan_cnt_q <= scan_cnt_q + CW'(1);
        end
        if (s1_v_q) begin
          carry_q <= run_s[WORD_W-1];
        end
      end
    end
  end

  // For every bit, a log-depth prefix finds the nearest used bit at or below it;
  // the free run ending there follows, with the run carried in from earlier words.
  always_comb begin
    for (int j = 0; j < WORD_W; j++) begin
      pre_s[j] = {rdata_q[j], WORD_SH'(j)};
    end
    for (int l = 0; l < WORD_SH; l++) begin
      for (int j = WORD_W - 1; j >= 0; j--) begin
        if (j >= (1 << l)) begin
          if (!pre_s[j][WORD_SH]) begin
            pre_s[j] = pre_s[j - (1 << l)];
          end
        end
      end
    end
    for (int j = 0; j < WORD_W; j++) begin
      if (pre_s[j][WORD_SH]) begin
        run_s[j] = POS_W'(j) - POS_W'(pre_s[j][WORD_SH-1:0]);
      end else begin
        run_s[j] = carry_q + POS_W'(j) + POS_W'(1);
      end
      gpos_s[j] = (POS_W'(s1_word_q) << WORD_SH) + POS_W'(j);
      hit_d[j]  = (run_s[j] >= POS_W'(cnt_q)) && (gpos_s[j] < limit_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_issue) begin
      s1_word_q <= scan_cnt_q[AW-1:0];
    end
    s2_word_q <= s1_word_q;
    if (s1_v_q) begin
      hit_q <= hit_d;
    end
  end

  // The lowest hit marks where the first long enough run completes.
  always_comb begin
    first_oh = hit_q & (~hit_q + WORD_W'(1));
    first_j  = '0;
    for (int k = 0; k < WORD_W; k++) begin
      if (first_oh[k]) begin
        first_j = first_j | WORD_SH'(k);
      end
    end
    any_hit    = |hit_q;
    start_calc = (POS_W'(s2_word_q) << WORD_SH) + POS_W'(first_j) + POS_W'(1)
                 - POS_W'(cnt_q);
  end

  assign scan_hit = s2_v_q && any_hit && !res_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_found_q <= 1'b0;
      res_bit_q   <= 1'b0;
      res_start_q <= '0;
    end else if (cmd_i.accept) begin
      res_found_q <= 1'b0;
      res_bit_q   <= 1'b0;
      res_start_q <= '0;
    end else if (cmd_i.acc_ex) begin
      if (in_range) begin
        res_found_q <= 1'b1;
        if (op_q == OP_TEST) begin
          res_bit_q <= rdata_q[idx_q[WORD_SH-1:0]];
        end
      end
    end else if (scan_hit) begin
      res_found_q <= 1'b1;
      res_start_q <= start_calc[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_found_q <= res_found_q;
      out_start_q <= res_start_q;
      out_bit_q   <= res_bit_q;
    end
  end

  assign status_o.clr_last   = clr_addr_q == AW'(WORDS - 1);
  assign status_o.cnt_zero   = cnt_q == '0;
  assign status_o.all_issued = scan_cnt_q == nw_q;
  assign status_o.scan_done  = res_found_q || (scan_cnt_q == nw_q && !s1_v_q && !s2_v_q);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign start_index_o = out_start_q;
  assign bit_value_o   = out_bit_q;

endmodule

/* hw/rtl/bitmap_run_allocator_top.sv */
// Bitmap run allocator: first-fit search for runs of free units in a usage map.
// The input channel (in_valid_i/in_ready_o) carries one operation per transaction:
// clear all, test a bit, write a bit, or scan for the lowest run of count_i free bits.
// The output channel (out_valid_o/out_ready_i) returns exactly one result transaction
// per input transaction, in order. The length register is written through cfg_we_i
// with cfg_wdata_i; the user must write it only while the block is idle, which the
// block itself does not enforce. It bounds every test, write and scan. A scan reads
// the map one 64-bit word per cycle through a three-stage search pipeline, a rate
// set by the single read port of the map memory; a run found early ends the scan sooner.
// Clear all sweeps the map to zero one word per cycle. After reset the map is swept
// to zero the same way; in_ready_o stays low until that pass ends. One item is
// worked on at a time. A finished result sits in an output register; the next
// transaction is accepted while it waits, and that one completes only once the
// receiver takes the result.
`include "bitmap_run_allocator_top_assert.svh"

module bitmap_run_allocator_top #(
  parameter int unsigned MAP_BYTES = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bra_pkg::LEN_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  operation_i,
  input  logic [bra_pkg::IDX_W-1:0]   bit_index_i,
  input  logic                        value_i,
  input  logic [bra_pkg::CNT_W-1:0]   count_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        found_o,
  output logic [bra_pkg::IDX_W-1:0]   start_index_o,
  output logic                        bit_value_o
);
  import bra_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  bra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd),
    .in_ready_o  (in_ready_o)
  );

  bra_datapath #(
    .MAP_BYTES (MAP_BYTES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .operation_i   (operation_i),
    .bit_index_i   (bit_index_i),
    .value_i       (value_i),
    .count_i       (count_i),
    .out_ready_i   (out_ready_i),
    .cmd_i         (ctrl_cmd),
    .status_o      (dp_status),
    .out_valid_o   (out_valid_o),
    .found_o       (found_o),
    .start_index_o (start_index_o),
    .bit_value_o   (bit_value_o)
  );

  // A result may only be loaded when the output register is empty or draining.
  `BRA_ASSERT(a_load_into_free_slot, ctrl_cmd.load_out |-> (!out_valid_o || out_ready_i))
  // After a transaction is taken the block is busy in the following cycle.
  `BRA_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o)
  // Clearing writes and scan reads never share a cycle.
  `BRA_ASSERT_NEVER(a_no_clear_during_scan, ctrl_cmd.scan_issue && ctrl_cmd.clr_step)

endmodule

/* sim/tb_bitmap_run_allocator_top.sv */
// Self-checking testbench for the bitmap run allocator: predicted replies versus DUT results.
`timescale 1ns / 100ps

module tb_bitmap_run_allocator_top;
  import bra_pkg::*;

  localparam int unsigned MAP_BYTES   = 128;
  localparam int unsigned MAP_BITS    = MAP_BYTES * 8;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_ITEMS = 145;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] start;
    logic             bit_value;
  } reply_t;

  // Mirrors the usage map and the length register, and keeps the replies still owed.
  class run_alloc_scoreboard;
    logic             usage_bits [MAP_BITS];
    logic [LEN_W-1:0] length_reg;
    reply_t           predicted_replies [$];
    int               mismatches;

    function new();
      foreach (usage_bits[i]) usage_bits[i] = 1'b0;
      length_reg = LEN_RESET;
      mismatches = 0;
    endfunction

    function int unsigned bits_in_use();
      int unsigned n;
      n = length_reg;
      if (n > MAP_BYTES) n = MAP_BYTES;
      return n * 8;
    endfunction

    function reply_t note_op(op_e op, logic [IDX_W-1:0] idx, logic val, logic [CNT_W-1:0] cnt);
      reply_t r;
      int unsigned limit;
      int unsigned run;
      r = '0;
      limit = bits_in_use();
      run = 0;
      case (op)
        OP_CLEAR: begin
          foreach (usage_bits[i]) usage_bits[i] = 1'b0;
        end
        OP_TEST: begin
          if (idx < limit) begin
            r.found = 1'b1;
            r.bit_value = usage_bits[idx];
          end
        end
        OP_WRITE: begin
          if (idx < limit) begin
            r.found = 1'b1;
            usage_bits[idx] = val;
          end
        end
        default: begin
          // First fit: the run must end inside the in-use length.
          if (cnt != 0) begin
            for (int unsigned i = 0; i < limit; i++) begin
              if (usage_bits[i]) begin
                run = 0;
              end else begin
                run++;
                if (run == cnt) begin
                  r.found = 1'b1;
                  r.start = IDX_W'(i + 1 - cnt);
                  break;
                end
              end
            end
          end
        end
      endcase
      predicted_replies.push_back(r);
      return r;
    endfunction

    function void check_reply(logic found, logic [IDX_W-1:0] start, logic bit_value);
      reply_t exp_r;
      if (predicted_replies.size() == 0) begin
        $display("%0t: result with no pending transaction: found %0b start %0d bit %0b",
                 $time, found, start, bit_value);
        mismatches++;
        return;
      end
      exp_r = predicted_replies.pop_front();
      if (found !== exp_r.found) begin
        $display("%0t: found expected %0b actual %0b", $time, exp_r.found, found);
        mismatches++;
      end
      if (start_index_differs(exp_r.start, start)) begin
        $display("%0t: start_index expected %0d actual %0d", $time, exp_r.start, start);
        mismatches++;
      end
      if (bit_value !== exp_r.bit_value) begin
        $display("%0t: bit_value expected %0b actual %0b", $time, exp_r.bit_value, bit_value);
        mismatches++;
      end
    endfunction

    function bit start_index_differs(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
      return a !== b;
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [LEN_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [1:0]       operation_i;
  logic [IDX_W-1:0] bit_index_i;
  logic             value_i;
  logic [CNT_W-1:0] count_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             found_o;
  logic [IDX_W-1:0] start_index_o;
  logic             bit_value_o;

  run_alloc_scoreboard sb;
  int  burst_left;
  bit  hold_request;

  bitmap_run_allocator_top #(
    .MAP_BYTES(MAP_BYTES)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .bit_index_i  (bit_index_i),
    .value_i      (value_i),
    .count_i      (count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .start_index_o(start_index_o),
    .bit_value_o  (bit_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offers one transaction, with a random gap whenever a burst runs out.
  task automatic send_item(input op_e op, input logic [IDX_W-1:0] idx, input logic val,
                           input logic [CNT_W-1:0] cnt, output reply_t r);
    int gap;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    operation_i <= op;
    bit_index_i <= idx;
    value_i     <= val;
    count_i     <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
    r = sb.note_op(op, idx, val, cnt);
    burst_left--;
  endtask

  // Lets every owed result drain, then writes the length register while the block is idle.
  task automatic write_length(input logic [LEN_W-1:0] len);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.predicted_replies.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.length_reg = len;
  endtask

  function automatic logic [IDX_W-1:0] pick_index(int unsigned limit);
    if (limit == 0 || $urandom_range(0, 9) == 0) return IDX_W'($urandom_range(0, MAP_BITS - 1));
    return IDX_W'($urandom_range(0, limit - 1));
  endfunction

  function automatic logic [CNT_W-1:0] pick_wide_count(int unsigned limit);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CNT_W'(limit);
      2: return CNT_W'(limit + 1);
      3: return CNT_W'($urandom_range(0, 2047));
      default: return CNT_W'($urandom_range(1, (limit > 0) ? limit + 8 : 8));
    endcase
  endfunction

  // Mostly allocate-then-mark and release sequences, with loose accesses and some noise.
  task automatic random_phase(input int n_items);
    int          sent;
    int          pick;
    int unsigned limit;
    int          run_len;
    int          k;
    logic [IDX_W-1:0] base;
    reply_t      r;
    reply_t      r_mark;
    sent = 0;
    limit = sb.bits_in_use();
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        run_len = $urandom_range(1, 12);
        send_item(OP_SCAN, pick_index(limit), 1'($urandom), CNT_W'(run_len), r);
        sent++;
        if (r.found) begin
          for (k = 0; k < run_len; k++) begin
            send_item(OP_WRITE, IDX_W'(r.start + k), 1'b1, CNT_W'($urandom), r_mark);
            sent++;
          end
        end
      end else if (pick < 55) begin
        base = pick_index(limit);
        run_len = $urandom_range(1, 12);
        for (k = 0; k < run_len && base + k < MAP_BITS; k++) begin
          send_item(OP_WRITE, IDX_W'(base + k), 1'b0, CNT_W'($urandom), r);
          sent++;
        end
      end else if (pick < 70) begin
        send_item(OP_TEST, pick_index(limit), 1'($urandom), CNT_W'($urandom), r);
        sent++;
      end else if (pick < 82) begin
        send_item(OP_WRITE, pick_index(limit), 1'($urandom), CNT_W'($urandom), r);
        sent++;
      end else if (pick < 96) begin
        send_item(OP_SCAN, pick_index(limit), 1'($urandom), pick_wide_count(limit), r);
        sent++;
      end else if (pick < 98) begin
        send_item(OP_CLEAR, pick_index(limit), 1'($urandom), CNT_W'($urandom), r);
        sent++;
      end else begin
        send_item(op_e'($urandom_range(0, 3)), IDX_W'($urandom), 1'($urandom),
                  CNT_W'($urandom), r);
        sent++;
      end
    end
  endtask

  // Result side: stalls on its own pattern; result_monitor checks every accepted result.
  initial begin : reply_sink
    int       mode;
    int       mode_left;
    int       hold_left;
    logic [7:0] pattern;
    logic     ready;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    pattern = 8'hff;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = $urandom_range(300, 500);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(30, 200);
        pattern = 8'($urandom) | 8'h01;
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        ready = 1'b0;
      end else begin
        case (mode)
          0: ready = 1'b1;
          1: begin
            ready = pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
          default: ready = 1'($urandom);
        endcase
      end
      out_ready_i <= ready;
    end
  end

  initial begin : result_monitor
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        sb.check_reply(found_o, start_index_o, bit_value_o);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: timeout, %0d results still owed", $time, sb.predicted_replies.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [LEN_W-1:0] phase_lengths [9];
    reply_t r;
    sb = new();
    burst_left = 0;
    hold_request = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    operation_i = OP_CLEAR;
    bit_index_i = '0;
    value_i     = 1'b0;
    count_i     = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // The map is swept to zero after reset; the input opens when that is done.
    do @(posedge clk_i); while (!in_ready_o);
    write_length(LEN_RESET);

    // Directed: full map, both ends of the index, run lengths at and past the map size.
    send_item(OP_TEST,  10'd0,    1'b0, 11'd0,    r);
    send_item(OP_WRITE, 10'd1023, 1'b1, 11'd0,    r);
    send_item(OP_TEST,  10'd1023, 1'b0, 11'd0,    r);
    send_item(OP_SCAN,  10'd0,    1'b0, 11'd1024, r);
    send_item(OP_SCAN,  10'd0,    1'b0, 11'd1023, r);
    send_item(OP_WRITE, 10'd0,    1'b1, 11'd2047, r);
    send_item(OP_SCAN,  10'd0,    1'b0, 11'd1022, r);
    send_item(OP_SCAN,  10'd1023, 1'b1, 11'd0,    r);
    send_item(OP_SCAN,  10'd0,    1'b0, 11'd2047, r);
    send_item(OP_CLEAR, 10'd1023, 1'b1, 11'd2047, r);
    send_item(OP_TEST,  10'd1023, 1'b0, 11'd0,    r);
    send_item(OP_SCAN,  10'd0,    1'b0, 11'd1024, r);
    send_item(OP_WRITE, 10'd682,  1'b1, 11'd0,    r);
    send_item(OP_WRITE, 10'd341,  1'b1, 11'd0,    r);
    send_item(OP_SCAN,  10'd0,    1'b0, 11'd400,  r);
    send_item(OP_WRITE, 10'd341,  1'b0, 11'd0,    r);
    send_item(OP_TEST,  10'd341,  1'b0, 11'd0,    r);
    send_item(OP_SCAN,  10'd0,    1'b0, 11'd1,    r);

    // Directed: one byte in use, accesses and runs at the edge of the in-use length.
    write_length(8'd1);
    send_item(OP_WRITE, 10'd8,    1'b1, 11'd0,    r);
    send_item(OP_TEST,  10'd7,    1'b0, 11'd0,    r);
    send_item(OP_SCAN,  10'd0,    1'b0, 11'd8,    r);
    send_item(OP_WRITE, 10'd7,    1'b1, 11'd0,    r);
    send_item(OP_SCAN,  10'd0,    1'b0, 11'd8,    r);
    send_item(OP_SCAN,  10'd0,    1'b0, 11'd7,    r);
    send_item(OP_TEST,  10'd1023, 1'b0, 11'd0,    r);

    phase_lengths = '{8'd1, 8'd0, 8'd8, 8'd255, 8'd3, 8'd128, 8'd200, 8'd16, 8'd0};
    phase_lengths[8] = LEN_W'($urandom_range(1, 128));
    foreach (phase_lengths[p]) begin
      write_length(phase_lengths[p]);
      // Hold the result side off for a long stretch so the block backs up its input.
      if (p == 2) hold_request = 1'b1;
      random_phase(PHASE_ITEMS);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.predicted_replies.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
